/* rtl/mwki_pkg.sv */
// package for the morph weight keyframe interpolator
// types, codes and defaults shared by all rtl files except mwki_ram; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mwki_pkg;

    localparam int MAX_KEYS_DEF    = 64;
    localparam int MAX_WEIGHTS_DEF = 8;

    localparam logic [1:0] OP_WR_TIME   = 2'd0;
    localparam logic [1:0] OP_WR_WEIGHT = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [1:0] CFG_KEY_COUNT    = 2'd0;
    localparam logic [1:0] CFG_WEIGHT_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         key_index;
        logic [2:0]         weight_index;
        logic [31:0]        time_value;
        logic signed [15:0] weight_value;
    } t_cmd_in;

    typedef struct packed {
        logic [2:0]         out_weight_index;
        logic signed [15:0] out_weight;
        logic               last;
        logic               no_data;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DIV_INIT,
        S_DIV,
        S_RD_LO,
        S_RD_HI,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_empty;
        logic scan_next;
        logic set_copy;
        logic set_lerp;
        logic div_init;
        logic div_step;
        logic sel_upper;
        logic latch_w1;
        logic mul;
        logic emit;
        logic w_next;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic hit;
        logic first;
        logic at_end;
        logic div_skip;
        logic div_done;
        logic w_last;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/mwki_ram.sv */
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mwki_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/mwki_ctrl.sv */
// query sequencer: key scan, alpha division, per weight blend
// depends on mwki_pkg
`timescale 1ns / 1ps
`default_nettype none

module mwki_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [1:0]          i_operation,
    input  wire mwki_pkg::t_dp_status i_status,
    output mwki_pkg::t_dp_cmd        o_cmd,
    output logic                     o_busy
);
    import mwki_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_operation == OP_QUERY) begin
                    if (i_status.empty) begin
                        o_cmd.emit_empty = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_status.hit) begin
                    if (i_status.first) begin
                        o_cmd.set_copy = 1'b1;
                        n_state        = S_RD_LO;
                    end else begin
                        o_cmd.set_lerp = 1'b1;
                        n_state        = S_DIV_INIT;
                    end
                end else if (i_status.at_end) begin
                    o_cmd.set_copy = 1'b1;
                    n_state        = S_RD_LO;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = i_status.div_skip ? S_RD_LO : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_RD_LO;
                end
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: begin
                o_cmd.sel_upper = 1'b1;
                o_cmd.latch_w1  = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                if (i_status.w_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.w_next = 1'b1;
                    n_state      = S_RD_LO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_IDLE)
        else $error("state not idle after reset");
    a_div_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && i_status.div_done |=> r_state == S_RD_LO)
        else $error("division did not hand over to weight loop");
    a_out_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && i_status.w_last |=> r_state == S_IDLE)
        else $error("query did not end after last weight");

endmodule

`default_nettype wire

/* rtl/mwki_dp.sv */
// datapath: key tables, config registers, scan, divider, blend, result register
// depends on mwki_pkg and mwki_ram
`timescale 1ns / 1ps
`default_nettype none

module mwki_dp #(
    parameter int MAX_KEYS    = mwki_pkg::MAX_KEYS_DEF,
    parameter int MAX_WEIGHTS = mwki_pkg::MAX_WEIGHTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire mwki_pkg::t_cmd_in i_cmd,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    input  wire mwki_pkg::t_dp_cmd i_dp_cmd,
    output mwki_pkg::t_dp_status   o_status,
    output logic                   o_valid,
    output mwki_pkg::t_result      o_result
);
    import mwki_pkg::*;

    localparam int KAW = $clog2(MAX_KEYS);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int WCW = $clog2(MAX_WEIGHTS + 1);
    localparam int AWW = $clog2(MAX_KEYS * MAX_WEIGHTS);

    logic [6:0]  r_key_count;
    logic [3:0]  r_weight_count;
    logic [CW-1:0]  n_nk, r_nk, r_idx;
    logic [WCW-1:0] n_nw, r_nw, r_wi;
    logic [31:0] r_t, r_tprev, r_num, r_den, r_rem;
    logic [KAW-1:0] r_lower, r_upper;
    logic [15:0] r_alpha;
    logic [3:0]  r_dcnt;
    logic signed [15:0] r_w1;
    logic signed [33:0] r_prod;

    logic        t_we, w_we;
    logic [31:0] t_rdata;
    logic [15:0] w_rdata;
    logic [AWW-1:0] w_waddr, w_raddr;
    logic [32:0] div_sh;
    logic        div_ge;
    logic signed [35:0] sum, sum_adj, quo;
    logic signed [15:0] sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count    <= '0;
            r_weight_count <= 4'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_KEY_COUNT) begin
                r_key_count <= i_cfg_data;
            end else if (i_cfg_index == CFG_WEIGHT_COUNT) begin
                r_weight_count <= i_cfg_data[3:0];
            end
        end
    end

    always_comb begin
        if (32'(r_key_count) > 32'(MAX_KEYS)) n_nk = CW'(MAX_KEYS);
        else                                   n_nk = CW'(r_key_count);
        if (r_weight_count == 4'd0)                       n_nw = WCW'(1);
        else if (32'(r_weight_count) > 32'(MAX_WEIGHTS)) n_nw = WCW'(MAX_WEIGHTS);
        else                                              n_nw = WCW'(r_weight_count);
    end

    assign t_we = i_accept && i_cmd.operation == OP_WR_TIME
                  && 32'(i_cmd.key_index) < 32'(MAX_KEYS);
    assign w_we = i_accept && i_cmd.operation == OP_WR_WEIGHT
                  && 32'(i_cmd.key_index) < 32'(MAX_KEYS)
                  && 32'(i_cmd.weight_index) < 32'(MAX_WEIGHTS);
    assign w_waddr = AWW'(32'(i_cmd.key_index) * MAX_WEIGHTS + 32'(i_cmd.weight_index));
    assign w_raddr = AWW'(32'(i_dp_cmd.sel_upper ? r_upper : r_lower) * MAX_WEIGHTS
                          + 32'(r_wi));

    mwki_ram #(.WIDTH(32), .DEPTH(MAX_KEYS)) u_times (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (KAW'(i_cmd.key_index)),
        .i_wdata (i_cmd.time_value),
        .i_raddr (r_idx[KAW-1:0]),
        .o_rdata (t_rdata)
    );

    mwki_ram #(.WIDTH(16), .DEPTH(MAX_KEYS * MAX_WEIGHTS)) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_cmd.weight_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign div_sh = {r_rem, 1'b0};
    assign div_ge = div_sh >= {1'b0, r_den};

    assign sum     = (36'(r_w1) <<< 16) + 36'(r_prod);
    assign sum_adj = sum[35] ? sum + 36'sd65535 : sum;
    assign quo     = sum_adj >>> 16;
    always_comb begin
        if (quo > 36'sd32767)       sat = 16'sh7fff;
        else if (quo < -36'sd32768) sat = 16'sh8000;
        else                        sat = quo[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_t   <= i_cmd.time_value;
            r_nk  <= n_nk;
            r_nw  <= n_nw;
            r_idx <= '0;
            r_wi  <= '0;
        end
        if (i_dp_cmd.scan_next) begin
            r_tprev <= t_rdata;
            r_idx   <= r_idx + CW'(1);
        end
        if (i_dp_cmd.set_copy) begin
            r_lower <= r_idx[KAW-1:0];
            r_upper <= r_idx[KAW-1:0];
            r_alpha <= '0;
        end
        if (i_dp_cmd.set_lerp) begin
            r_lower <= r_idx[KAW-1:0] - KAW'(1);
            r_upper <= r_idx[KAW-1:0];
            r_num   <= r_t - r_tprev;
            r_den   <= t_rdata - r_tprev;
        end
        if (i_dp_cmd.div_init) begin
            r_rem  <= r_num;
            r_dcnt <= '0;
            if (r_den == 32'd0)       r_alpha <= '0;
            else if (r_num >= r_den)  r_alpha <= 16'hffff;
            else                      r_alpha <= '0;
        end
        if (i_dp_cmd.div_step) begin
            r_rem   <= div_ge ? 32'(div_sh - {1'b0, r_den}) : div_sh[31:0];
            r_alpha <= {r_alpha[14:0], div_ge};
            r_dcnt  <= r_dcnt + 4'd1;
        end
        if (i_dp_cmd.latch_w1) begin
            r_w1 <= w_rdata;
        end
        if (i_dp_cmd.mul) begin
            r_prod <= (17'($signed(w_rdata)) - 17'(r_w1)) * $signed({1'b0, r_alpha});
        end
        if (i_dp_cmd.w_next) begin
            r_wi <= r_wi + WCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_dp_cmd.emit || i_dp_cmd.emit_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit_empty) begin
            o_result <= '{out_weight_index: 3'd0, out_weight: 16'sd0,
                          last: 1'b1, no_data: 1'b1};
        end else if (i_dp_cmd.emit) begin
            o_result <= '{out_weight_index: 3'(r_wi), out_weight: sat,
                          last: r_wi == r_nw - WCW'(1), no_data: 1'b0};
        end
    end

    assign o_status = '{
        empty:    r_key_count == 7'd0,
        hit:      t_rdata > r_t,
        first:    r_idx == '0,
        at_end:   r_idx == r_nk - CW'(1),
        div_skip: r_den == 32'd0 || r_num >= r_den,
        div_done: r_dcnt == 4'd15,
        w_last:   r_wi == r_nw - WCW'(1)
    };

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.no_data |-> o_result.last && o_result.out_weight == 16'sd0)
        else $error("empty result malformed");
    a_wi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.emit |-> 32'(r_wi) < 32'(MAX_WEIGHTS))
        else $error("weight index beyond table row");
    a_zero_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.div_init && r_den == 32'd0 |=> r_alpha == 16'd0)
        else $error("zero span must give zero alpha");

endmodule

`default_nettype wire

/* rtl/morph_weight_keyframe_interpolator_core.sv */
// morph weight keyframe interpolator, top level
// query: a linear key scan compares each key in turn; when blending, alpha setup and
// bit-serial division follow; per weight, both keys are read, blended and strobed out;
// writes and empty queries never raise busy; the key scan and alpha divider set latency
// synchronous active-low reset: key_count 0, weight_count 1, tables keep contents
// results cannot be stalled by the receiver
`timescale 1ns / 1ps
`default_nettype none

module morph_weight_keyframe_interpolator_core #(
    parameter int MAX_KEYS    = mwki_pkg::MAX_KEYS_DEF,
    parameter int MAX_WEIGHTS = mwki_pkg::MAX_WEIGHTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire mwki_pkg::t_cmd_in i_cmd,
    output logic                   o_busy,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    output logic                   o_valid,
    output mwki_pkg::t_result      o_result
);
    import mwki_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mwki_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_cmd.operation),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_busy      (o_busy)
    );

    mwki_dp #(.MAX_KEYS(MAX_KEYS), .MAX_WEIGHTS(MAX_WEIGHTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (i_start && !o_busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_dp_cmd    (dp_cmd),
        .o_status    (dp_status),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire
